// ===== hdl/les_pkg.sv =====
// LED effect sequencer: shared types, constants and codes.
// No dependencies; imported by every module of the block.
package les_pkg;

  localparam int NUM_LEDS      = 7;
  localparam int LED_W         = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int DONE_W        = $clog2(NUM_LEDS + 1);
  localparam int FINISH_QUORUM = 5;
  localparam int ITER_W        = 9;

  typedef enum logic [1:0] {
    REQ_TICK     = 2'd0,
    REQ_SET_PROG = 2'd1,
    REQ_SET_ALL  = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    PRG_OFF     = 3'd0,
    PRG_NOMINAL = 3'd1,
    PRG_MAX     = 3'd2,
    PRG_BRAKE   = 3'd3,
    PRG_RAMP    = 3'd4,
    PRG_FLASH   = 3'd5,
    PRG_MARK    = 3'd6
  } prog_t;

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_RISE  = 2'd1;
  localparam logic [1:0] PH_FALL  = 2'd2;

  typedef enum logic [2:0] {
    CFG_MAX_LEVEL  = 3'd0,
    CFG_MIN_LEVEL  = 3'd1,
    CFG_SLOW_FLOOR = 3'd2,
    CFG_BRAKE      = 3'd3,
    CFG_MARK       = 3'd4,
    CFG_THRESHOLD  = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_RUN  = 2'd1,
    S_EMIT = 2'd2
  } state_t;

  typedef struct packed {
    logic [2:0]        prog;
    logic [7:0]        level;
    logic [1:0]        phase;
    logic [7:0]        speed;
    logic [7:0]        step;
    logic [ITER_W-1:0] iteration;
    logic [7:0]        nominal;
  } slot_t;

  // slot after reset: program off, step one, all else zero (field order)
  localparam slot_t SLOT_RESET = {PRG_OFF, 8'd0, PH_START, 8'd0, 8'd1,
                                  ITER_W'(0), 8'd0};

  typedef struct packed {
    logic [7:0] max_level;
    logic [7:0] min_level;
    logic [7:0] slow_floor_level;
    logic [7:0] brake_level;
    logic [7:0] mark_level;
    logic [9:0] on_threshold;
  } cfg_t;

endpackage

// ===== hdl/les_slot_file.sv =====
// Per-LED program slots held in flip-flops, one write port, one read port.
// Depends on les_pkg.
module les_slot_file
  import les_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [LED_W-1:0] rd_idx,
  output slot_t            rd_slot,
  input  logic             wr_en,
  input  logic [LED_W-1:0] wr_idx,
  input  slot_t            wr_slot
);

  slot_t slots_r [NUM_LEDS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        slots_r[i] <= SLOT_RESET;
      end
    end else if (wr_en) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        if (wr_idx == LED_W'(i)) slots_r[i] <= wr_slot;
      end
    end
  end

  always_comb begin
    rd_slot = '0;
    for (int i = 0; i < NUM_LEDS; i++) begin
      if (rd_idx == LED_W'(i)) rd_slot = slots_r[i];
    end
  end

endmodule

// ===== hdl/les_update.sv =====
// Shared program unit: advances one LED slot by one tick.
// Depends on les_pkg.
module les_update
  import les_pkg::*;
(
  input  cfg_t  cfg,
  input  slot_t slot_in,
  output slot_t slot_out,
  output logic  finished
);

  logic [ITER_W-1:0] it_add;
  logic [ITER_W-1:0] it_one;
  logic [7:0]        lvl_up;
  logic [7:0]        lvl_dn;
  logic [7:0]        lvl_tmp;
  logic [7:0]        floor_lvl;
  logic              add_over;
  logic              one_over;

  assign it_add    = slot_in.iteration + ITER_W'(slot_in.step);
  assign it_one    = slot_in.iteration + ITER_W'(1);
  assign add_over  = it_add > ITER_W'(slot_in.speed);
  assign one_over  = it_one > ITER_W'(slot_in.speed);
  assign lvl_up    = (slot_in.level == 8'hFF) ? slot_in.level : slot_in.level + 8'd1;
  assign lvl_dn    = (slot_in.level == 8'h00) ? slot_in.level : slot_in.level - 8'd1;
  assign floor_lvl = (slot_in.nominal == cfg.max_level) ? cfg.min_level
                                                        : cfg.slow_floor_level;

  always_comb begin
    slot_out = slot_in;
    finished = 1'b1;
    lvl_tmp  = slot_in.level;
    case (slot_in.prog)
      PRG_OFF, PRG_NOMINAL, PRG_MAX: begin
        // settle: fixed level, sequencing fields cleared
        case (slot_in.prog)
          PRG_NOMINAL: slot_out.level = slot_in.nominal;
          PRG_MAX:     slot_out.level = cfg.max_level;
          default:     slot_out.level = 8'd0;
        endcase
        slot_out.speed     = '0;
        slot_out.phase     = PH_START;
        slot_out.iteration = '0;
      end
      PRG_BRAKE: slot_out.level = cfg.brake_level;
      PRG_MARK:  slot_out.level = cfg.mark_level;
      PRG_RAMP: begin
        case (slot_in.phase)
          PH_START: begin
            slot_out.iteration = '0;
            slot_out.phase     = PH_RISE;
            finished           = 1'b0;
          end
          PH_RISE: begin
            slot_out.iteration = add_over ? '0 : it_add;
            lvl_tmp            = add_over ? lvl_up : slot_in.level;
            slot_out.level     = lvl_tmp;
            if (lvl_tmp > cfg.max_level) begin
              slot_out.level     = cfg.max_level;
              slot_out.phase     = PH_FALL;
              slot_out.iteration = '0;
            end
          end
          PH_FALL: begin
            slot_out.iteration = add_over ? '0 : it_add;
            lvl_tmp            = add_over ? lvl_dn : slot_in.level;
            slot_out.level     = lvl_tmp;
            if (lvl_tmp <= floor_lvl) begin
              slot_out.level     = floor_lvl;
              slot_out.phase     = PH_RISE;
              slot_out.iteration = '0;
            end
          end
          default: begin
            slot_out.phase = PH_START;
            finished       = 1'b0;
          end
        endcase
      end
      PRG_FLASH: begin
        case (slot_in.phase)
          PH_START: begin
            slot_out.iteration = '0;
            slot_out.phase     = PH_RISE;
            finished           = 1'b0;
          end
          PH_RISE: begin
            slot_out.iteration = one_over ? '0 : it_one;
            if (one_over) begin
              slot_out.level = (slot_in.level == cfg.max_level) ? 8'd0 : cfg.max_level;
            end
          end
          default: begin
            slot_out.phase = PH_START;
            finished       = 1'b0;
          end
        endcase
      end
      // unassigned program code: slot untouched, not finished
      default: finished = 1'b0;
    endcase
  end

endmodule

// ===== hdl/led_effect_sequencer_core.sv =====
// LED effect sequencer top level: sequencer, config registers, result stage.
// Depends on les_pkg, les_slot_file and les_update.
//
// Usage:
//   Input items are taken when start is high and busy is low. A set item
//   (program only or whole slot) is written in that same edge; busy stays
//   low, so a set item can follow in every cycle and gives no result.
//   A tick item raises busy for an update pass followed by a read-back
//   pass. The update pass runs each LED's program through the one shared
//   update unit, one slot per cycle, counting finished programs; the
//   read-back pass then reads the slots back in LED order. Results appear
//   on the out_ ports one per cycle with out_strobe, registered from the
//   read-back pass; out_last marks the final one.
//   The finished count is only known after the last slot, which is why the
//   read-back pass follows the update pass. The next item is taken only
//   after busy drops at the end of the read-back pass, so ticks never
//   overlap: the single slot port and update unit serve both passes.
//   The receiver cannot stall; each result is shown for exactly one cycle.
//   Config writes (cfg_we, cfg_index, cfg_wdata) take effect at once;
//   unknown indexes are ignored. Synchronous reset restores register
//   defaults and all slots (program off, step one, everything else zero).
module led_effect_sequencer_core
  import les_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // item channel
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_req_type,
  input  logic [2:0] in_led_index,
  input  logic [2:0] in_program_req,
  input  logic [7:0] in_level,
  input  logic [1:0] in_phase,
  input  logic [7:0] in_speed,
  input  logic [7:0] in_step_size,
  input  logic [7:0] in_nominal,
  // result channel
  output logic       out_strobe,
  output logic [2:0] out_led_number,
  output logic [9:0] out_duty,
  output logic       out_digital_on,
  output logic       out_all_finished,
  output logic       out_last,
  // config port
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [9:0] cfg_wdata
);

  state_t            state_r, state_nxt;
  logic [LED_W-1:0]  cnt_r, cnt_nxt;
  logic [DONE_W-1:0] done_r, done_nxt;
  cfg_t              cfg_r;

  logic              accept;
  logic              cnt_last;
  logic              set_ok;

  logic [LED_W-1:0]  slot_idx;
  slot_t             rd_slot;
  slot_t             upd_slot;
  slot_t             wr_slot;
  logic              wr_en;
  logic              upd_fin;

  // result stage
  logic              strobe_r, strobe_nxt;
  logic [2:0]        num_r;
  logic [9:0]        duty_r;
  logic              on_r;
  logic              allfin_r;
  logic              last_r;
  logic [9:0]        duty_rd;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign cnt_last = (cnt_r == LED_W'(NUM_LEDS - 1));
  // set items to a slot past the last LED are dropped
  assign set_ok   = (4'(in_led_index) < 4'(NUM_LEDS));

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_level        <= 8'd254;
      cfg_r.min_level        <= 8'd0;
      cfg_r.slow_floor_level <= 8'd64;
      cfg_r.brake_level      <= 8'd255;
      cfg_r.mark_level       <= 8'd32;
      cfg_r.on_threshold     <= 10'd511;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_LEVEL:  cfg_r.max_level        <= cfg_wdata[7:0];
        CFG_MIN_LEVEL:  cfg_r.min_level        <= cfg_wdata[7:0];
        CFG_SLOW_FLOOR: cfg_r.slow_floor_level <= cfg_wdata[7:0];
        CFG_BRAKE:      cfg_r.brake_level      <= cfg_wdata[7:0];
        CFG_MARK:       cfg_r.mark_level       <= cfg_wdata[7:0];
        CFG_THRESHOLD:  cfg_r.on_threshold     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- slots
  // idle: port addressed by the set item; busy: by the LED counter
  assign slot_idx = busy ? cnt_r : LED_W'(in_led_index);

  les_slot_file u_slots (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (slot_idx),
    .rd_slot (rd_slot),
    .wr_en   (wr_en),
    .wr_idx  (slot_idx),
    .wr_slot (wr_slot)
  );

  les_update u_update (
    .cfg      (cfg_r),
    .slot_in  (rd_slot),
    .slot_out (upd_slot),
    .finished (upd_fin)
  );

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      done_r   <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      done_r   <= done_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    done_nxt   = done_r;
    strobe_nxt = 1'b0;
    wr_en      = 1'b0;
    wr_slot    = upd_slot;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_req_type)
            REQ_TICK: begin
              state_nxt = S_RUN;
              cnt_nxt   = '0;
              done_nxt  = '0;
            end
            REQ_SET_PROG: begin
              wr_en        = set_ok;
              wr_slot      = rd_slot;
              wr_slot.prog = in_program_req;
            end
            REQ_SET_ALL: begin
              // iteration counter is kept across a full set
              wr_en           = set_ok;
              wr_slot         = rd_slot;
              wr_slot.prog    = in_program_req;
              wr_slot.level   = in_level;
              wr_slot.phase   = in_phase;
              wr_slot.speed   = in_speed;
              wr_slot.step    = in_step_size;
              wr_slot.nominal = in_nominal;
            end
            default: ;
          endcase
        end
      end
      S_RUN: begin
        wr_en    = 1'b1;
        done_nxt = done_r + DONE_W'(upd_fin);
        if (cnt_last) begin
          state_nxt = S_EMIT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + LED_W'(1);
        end
      end
      S_EMIT: begin
        strobe_nxt = 1'b1;
        if (cnt_last) begin
          state_nxt = S_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + LED_W'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- results
  assign duty_rd = {rd_slot.level, 2'b00};

  always_ff @(posedge clk) begin
    num_r    <= 3'(cnt_r);
    duty_r   <= duty_rd;
    on_r     <= duty_rd > cfg_r.on_threshold;
    allfin_r <= done_r >= DONE_W'(FINISH_QUORUM);
    last_r   <= cnt_last;
  end

  assign out_strobe       = strobe_r;
  assign out_led_number   = num_r;
  assign out_duty         = duty_r;
  assign out_digital_on   = on_r;
  assign out_all_finished = allfin_r;
  assign out_last         = strobe_r && last_r;

`ifndef SYNTH
  a_strobe_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == S_EMIT))
    else $error("result strobe without read-back pass");

  a_tick_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req_type == REQ_TICK) |=> (state_r == S_RUN && cnt_r == '0))
    else $error("tick item did not start the update pass");

  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (cnt_r <= LED_W'(NUM_LEDS - 1)))
    else $error("LED counter out of range");

  a_last_ends_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> (state_r == S_IDLE && $past(state_r == S_EMIT)))
    else $error("last result while sequencer still busy");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for led_effect_sequencer_core: set and tick items,
// with results checked against a cycle-free model of the seven LED slots.
// Depends on les_pkg and the RTL of the block; nothing else.
module testbench;
  import les_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 12;
  // a tick shows its last result at the end of its read-back pass
  localparam int DRAIN_CYCLES   = 2 * NUM_LEDS + 4;
  localparam int TIMEOUT_CYCLES = 200000;

  // codes the fields allow but the package does not name
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [2:0] PRG_SEVEN  = 3'd7;
  localparam logic [1:0] PH_UNUSED  = 2'd3;

  typedef struct {
    logic [1:0] kind;
    logic [2:0] led_index;
    logic [2:0] prog;
    logic [7:0] level;
    logic [1:0] phase;
    logic [7:0] speed;
    logic [7:0] step;
    logic [7:0] nominal;
  } led_cmd_t;

  typedef struct {
    logic [2:0] led_number;
    logic [9:0] duty;
    logic       digital_on;
    logic       all_finished;
    logic       last;
  } led_report_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] in_req_type = '0;
  logic [2:0] in_led_index = '0;
  logic [2:0] in_program_req = '0;
  logic [7:0] in_level = '0;
  logic [1:0] in_phase = '0;
  logic [7:0] in_speed = '0;
  logic [7:0] in_step_size = '0;
  logic [7:0] in_nominal = '0;
  logic       out_strobe;
  logic [2:0] out_led_number;
  logic [9:0] out_duty;
  logic       out_digital_on;
  logic       out_all_finished;
  logic       out_last;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [9:0] cfg_wdata = '0;

  // register mirror, reset values
  logic [7:0] max_lvl = 8'd254;
  logic [7:0] min_lvl = 8'd0;
  logic [7:0] slow_floor_lvl = 8'd64;
  logic [7:0] brake_lvl = 8'd255;
  logic [7:0] mark_lvl = 8'd32;
  logic [9:0] on_thr = 10'd511;

  // slot mirror
  logic [2:0]        slot_prog    [NUM_LEDS];
  logic [7:0]        slot_level   [NUM_LEDS];
  logic [1:0]        slot_phase   [NUM_LEDS];
  logic [7:0]        slot_speed   [NUM_LEDS];
  logic [7:0]        slot_step    [NUM_LEDS];
  logic [ITER_W-1:0] slot_iter    [NUM_LEDS];
  logic [7:0]        slot_nominal [NUM_LEDS];

  led_report_t led_report_q[$];
  int          mismatch_count = 0;
  int          burst_left = 0;

  led_effect_sequencer_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_led_index     (in_led_index),
    .in_program_req   (in_program_req),
    .in_level         (in_level),
    .in_phase         (in_phase),
    .in_speed         (in_speed),
    .in_step_size     (in_step_size),
    .in_nominal       (in_nominal),
    .out_strobe       (out_strobe),
    .out_led_number   (out_led_number),
    .out_duty         (out_duty),
    .out_digital_on   (out_digital_on),
    .out_all_finished (out_all_finished),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------
  // Slot model
  // ---------------------------------------------------------------------

  // off, nominal and max park the slot at a fixed level
  function automatic void settle_slot(int i, logic [7:0] lvl);
    slot_level[i] = lvl;
    slot_speed[i] = '0;
    slot_phase[i] = PH_START;
    slot_iter[i]  = '0;
  endfunction

  // runs one LED's program, returns 1 when it reports finished
  function automatic bit run_slot(int i);
    logic [7:0] ramp_floor;
    case (slot_prog[i])
      PRG_OFF: begin
        settle_slot(i, 8'd0);
        return 1'b1;
      end
      PRG_NOMINAL: begin
        settle_slot(i, slot_nominal[i]);
        return 1'b1;
      end
      PRG_MAX: begin
        settle_slot(i, max_lvl);
        return 1'b1;
      end
      PRG_BRAKE: begin
        slot_level[i] = brake_lvl;
        return 1'b1;
      end
      PRG_MARK: begin
        slot_level[i] = mark_lvl;
        return 1'b1;
      end
      PRG_RAMP: begin
        case (slot_phase[i])
          PH_START: begin
            slot_iter[i]  = '0;
            slot_phase[i] = PH_RISE;
            return 1'b0;
          end
          PH_RISE: begin
            slot_iter[i] = slot_iter[i] + slot_step[i];
            if (slot_iter[i] > slot_speed[i]) begin
              slot_iter[i] = '0;
              if (slot_level[i] != 8'd255) slot_level[i] = slot_level[i] + 8'd1;
            end
            if (slot_level[i] > max_lvl) begin
              slot_level[i] = max_lvl;
              slot_phase[i] = PH_FALL;
              slot_iter[i]  = '0;
            end
            return 1'b1;
          end
          PH_FALL: begin
            slot_iter[i] = slot_iter[i] + slot_step[i];
            if (slot_iter[i] > slot_speed[i]) begin
              slot_iter[i] = '0;
              if (slot_level[i] != 8'd0) slot_level[i] = slot_level[i] - 8'd1;
            end
            // full-brightness LEDs ramp down further
            ramp_floor = (slot_nominal[i] == max_lvl) ? min_lvl : slow_floor_lvl;
            if (slot_level[i] <= ramp_floor) begin
              slot_level[i] = ramp_floor;
              slot_phase[i] = PH_RISE;
              slot_iter[i]  = '0;
            end
            return 1'b1;
          end
          default: begin
            slot_phase[i] = PH_START;
            return 1'b0;
          end
        endcase
      end
      PRG_FLASH: begin
        case (slot_phase[i])
          PH_START: begin
            slot_iter[i]  = '0;
            slot_phase[i] = PH_RISE;
            return 1'b0;
          end
          PH_RISE: begin
            slot_iter[i] = slot_iter[i] + 1'b1;
            if (slot_iter[i] > slot_speed[i]) begin
              slot_iter[i]  = '0;
              slot_level[i] = (slot_level[i] == max_lvl) ? 8'd0 : max_lvl;
            end
            return 1'b1;
          end
          default: begin
            slot_phase[i] = PH_START;
            return 1'b0;
          end
        endcase
      end
      default: return 1'b0;  // program seven idles, never finished
    endcase
  endfunction

  // applies one accepted item; a tick queues one report per LED
  function automatic void advance_led_slots(led_cmd_t c);
    int          done_count;
    led_report_t r;
    done_count = 0;
    if (c.kind == REQ_SET_PROG || c.kind == REQ_SET_ALL) begin
      if (c.led_index < NUM_LEDS) begin
        slot_prog[c.led_index] = c.prog;
        if (c.kind == REQ_SET_ALL) begin
          // iteration count is left alone
          slot_level[c.led_index]   = c.level;
          slot_phase[c.led_index]   = c.phase;
          slot_speed[c.led_index]   = c.speed;
          slot_step[c.led_index]    = c.step;
          slot_nominal[c.led_index] = c.nominal;
        end
      end
    end else if (c.kind == REQ_TICK) begin
      for (int i = 0; i < NUM_LEDS; i++) done_count += run_slot(i);
      for (int i = 0; i < NUM_LEDS; i++) begin
        r.led_number   = 3'(i);
        r.duty         = {slot_level[i], 2'b00};
        r.digital_on   = (r.duty > on_thr);
        r.all_finished = (done_count >= FINISH_QUORUM);
        r.last         = (i == NUM_LEDS - 1);
        led_report_q.push_back(r);
      end
    end
  endfunction

  // ---------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------

  // Sends one item. The sender runs in bursts; a new burst may open with a
  // gap. start stays high when items follow back to back, so it is never
  // lowered and raised in the same step.
  task automatic issue_item(led_cmd_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start          <= 1'b1;
    in_req_type    <= c.kind;
    in_led_index   <= c.led_index;
    in_program_req <= c.prog;
    in_level       <= c.level;
    in_phase       <= c.phase;
    in_speed       <= c.speed;
    in_step_size   <= c.step;
    in_nominal     <= c.nominal;
    @(posedge clk);
    while (busy) @(posedge clk);
    advance_led_slots(c);
  endtask

  task automatic send_set(logic [1:0] kind, logic [2:0] idx, logic [2:0] prog,
                          logic [7:0] lvl, logic [1:0] ph, logic [7:0] spd,
                          logic [7:0] stp, logic [7:0] nom);
    led_cmd_t c;
    c = '{kind, idx, prog, lvl, ph, spd, stp, nom};
    issue_item(c);
  endtask

  task automatic send_tick();
    send_set(REQ_TICK, 3'd0, PRG_OFF, 8'd0, PH_START, 8'd0, 8'd0, 8'd0);
  endtask

  // holds the sender until every report is in and the block has settled
  task automatic drain_results();
    start <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (led_report_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [9:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_MAX_LEVEL:  max_lvl = val[7:0];
      CFG_MIN_LEVEL:  min_lvl = val[7:0];
      CFG_SLOW_FLOOR: slow_floor_lvl = val[7:0];
      CFG_BRAKE:      brake_lvl = val[7:0];
      CFG_MARK:       mark_lvl = val[7:0];
      CFG_THRESHOLD:  on_thr = val;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(int unsigned mx, int unsigned mn, int unsigned sf,
                              int unsigned br, int unsigned mk, int unsigned th);
    drain_results();
    write_reg(CFG_MAX_LEVEL, 10'(mx));
    write_reg(CFG_MIN_LEVEL, 10'(mn));
    write_reg(CFG_SLOW_FLOOR, 10'(sf));
    write_reg(CFG_BRAKE, 10'(br));
    write_reg(CFG_MARK, 10'(mk));
    write_reg(CFG_THRESHOLD, 10'(th));
  endtask

  // Mostly ticks and whole-slot sets that park ramps and flashes near their
  // turning points with short periods, so phases flip often; the rest is
  // program-only sets, unused request type and sets to the missing slot.
  function automatic led_cmd_t random_cmd();
    led_cmd_t    c;
    int unsigned pick;
    int          lvl;
    c.kind      = 2'($urandom_range(0, 3));
    c.led_index = 3'($urandom_range(0, 7));
    c.prog      = 3'($urandom_range(0, 7));
    c.level     = 8'($urandom_range(0, 255));
    c.phase     = 2'($urandom_range(0, 3));
    c.speed     = 8'($urandom_range(0, 255));
    c.step      = 8'($urandom_range(0, 255));
    c.nominal   = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      c.kind = REQ_TICK;
      return c;
    end
    if (pick >= 90 && pick < 95) begin
      c.kind = REQ_UNUSED;
      return c;
    end
    c.kind = (pick < 76) ? REQ_SET_ALL : REQ_SET_PROG;
    c.led_index = (pick >= 95) ? 3'($urandom_range(NUM_LEDS, 7))
                               : 3'($urandom_range(0, NUM_LEDS - 1));
    if ($urandom_range(0, 1)) c.prog = $urandom_range(0, 1) ? PRG_RAMP : PRG_FLASH;
    case ($urandom_range(0, 2))
      0: lvl = int'(max_lvl) + int'($urandom_range(0, 4)) - 2;
      1: lvl = int'($urandom_range(0, 1) ? slow_floor_lvl : min_lvl)
               + int'($urandom_range(0, 4)) - 2;
      default: lvl = int'(c.level);
    endcase
    if (lvl < 0) lvl = 0;
    if (lvl > 255) lvl = 255;
    c.level = 8'(lvl);
    c.phase = ($urandom_range(0, 7) == 0) ? PH_UNUSED : 2'($urandom_range(0, 2));
    if ($urandom_range(0, 9) < 7) c.speed = 8'($urandom_range(0, 2));
    if ($urandom_range(0, 1)) c.step = 8'($urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) c.nominal = max_lvl;
    return c;
  endfunction

  // counts only items that touch the block
  task automatic run_random(int n);
    led_cmd_t c;
    int       counted;
    counted = 0;
    while (counted < n) begin
      c = random_cmd();
      issue_item(c);
      if (c.kind == REQ_TICK ||
          (c.kind != REQ_UNUSED && c.led_index < NUM_LEDS)) counted++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    led_report_t want;
    if (rst_n && out_strobe) begin
      if (led_report_q.size() == 0) begin
        $display("%0t: result with no item pending: expected none, actual led %0d duty %0d",
                 $time, out_led_number, out_duty);
        mismatch_count++;
      end else begin
        want = led_report_q.pop_front();
        check_field("led_number", want.led_number, out_led_number);
        check_field("duty", want.duty, out_duty);
        check_field("digital_on", want.digital_on, out_digital_on);
        check_field("all_finished", want.all_finished, out_all_finished);
        check_field("last", want.last, out_last);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // all slots off after reset: zero duty, all seven finished
  task automatic test_reset_state();
    send_tick();
  endtask

  task automatic test_programs();
    // one of each program but off, field extremes on the way
    send_set(REQ_SET_ALL, 3'd0, PRG_NOMINAL, 8'd0, PH_START, 8'd255, 8'd255, 8'd200);
    send_set(REQ_SET_ALL, 3'd1, PRG_MAX, 8'd17, PH_FALL, 8'd9, 8'd0, 8'd255);
    send_set(REQ_SET_ALL, 3'd2, PRG_BRAKE, 8'd0, PH_RISE, 8'd0, 8'd1, 8'd0);
    // ramp at full level: increment saturates, then clamps to the ceiling
    send_set(REQ_SET_ALL, 3'd3, PRG_RAMP, 8'd255, PH_RISE, 8'd0, 8'd1, 8'd0);
    send_set(REQ_SET_ALL, 3'd4, PRG_FLASH, 8'd0, PH_START, 8'd0, 8'd1, 8'd0);
    send_set(REQ_SET_ALL, 3'd5, PRG_MARK, 8'd255, PH_UNUSED, 8'd255, 8'd0, 8'd255);
    // program seven leaves its level alone and is never finished
    send_set(REQ_SET_ALL, 3'd6, PRG_SEVEN, 8'd123, PH_START, 8'd0, 8'd1, 8'd0);
    send_tick();
    send_tick();
    // ramp at zero going down: decrement saturates; nominal at max picks min floor
    send_set(REQ_SET_ALL, 3'd3, PRG_RAMP, 8'd0, PH_FALL, 8'd0, 8'd255, 8'd254);
    // unused phases fall back to start
    send_set(REQ_SET_ALL, 3'd4, PRG_FLASH, 8'd50, PH_UNUSED, 8'd0, 8'd1, 8'd0);
    send_set(REQ_SET_ALL, 3'd2, PRG_RAMP, 8'd100, PH_UNUSED, 8'd0, 8'd1, 8'd0);
    send_set(REQ_SET_PROG, 3'd1, PRG_OFF, 8'd255, PH_UNUSED, 8'd255, 8'd255, 8'd255);
    // ignored: unused request type and the missing slot
    send_set(REQ_UNUSED, 3'd0, PRG_MAX, 8'd255, PH_RISE, 8'd0, 8'd0, 8'd0);
    send_set(REQ_SET_ALL, 3'd7, PRG_MAX, 8'd255, PH_RISE, 8'd0, 8'd0, 8'd0);
    send_set(REQ_SET_PROG, 3'd7, PRG_BRAKE, 8'd0, PH_START, 8'd0, 8'd0, 8'd0);
    send_tick();  // only four finished
    send_tick();
    send_set(REQ_SET_ALL, 3'd0, PRG_FLASH, 8'd0, PH_FALL, 8'd0, 8'd1, 8'd0);
    send_set(REQ_SET_ALL, 3'd5, PRG_RAMP, 8'd70, PH_FALL, 8'd0, 8'd2, 8'd10);
    send_tick();
    send_tick();
  endtask

  // register corners, then a mid setting and a random one
  task automatic test_config_settings();
    apply_config(0, 0, 0, 0, 0, 0);
    run_random(30);
    apply_config(254, 254, 254, 255, 255, 1023);
    run_random(30);
    apply_config(100, 20, 60, 200, 10, 300);
    run_random(30);
    apply_config($urandom_range(0, 254), $urandom_range(0, 254), $urandom_range(0, 254),
                 $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1023));
    run_random(30);
  endtask

  // back at reset values; the sender holds off once mid-run
  task automatic test_random_traffic();
    apply_config(254, 0, 64, 255, 32, 511);
    run_random(60);
    drain_results();
    run_random(60);
  endtask

  initial begin
    for (int i = 0; i < NUM_LEDS; i++) begin
      slot_prog[i]    = PRG_OFF;
      slot_level[i]   = '0;
      slot_phase[i]   = PH_START;
      slot_speed[i]   = '0;
      slot_step[i]    = 8'd1;
      slot_iter[i]    = '0;
      slot_nominal[i] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_programs();
    test_config_settings();
    test_random_traffic();
    drain_results();

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog: a hung handshake or missing reports end up here
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("TEST FAILED");
    $finish;
  end

endmodule
